>>> sv/mscs_pkg.sv
package mscs_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    localparam logic [5:0]  OP_RTYPE = 6'd0;
    localparam logic [5:0]  OP_J     = 6'd2;
    localparam logic [5:0]  OP_BEQ   = 6'd4;
    localparam logic [5:0]  OP_LW    = 6'd35;
    localparam logic [5:0]  OP_SW    = 6'd43;

    localparam logic [31:0] JUMP_HI_MASK = 32'hf000_0000;

    typedef enum logic [1:0] {
        MODE_LOAD_MEM = 2'd0,
        MODE_LOAD_REG = 2'd1,
        MODE_STEP     = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CLS_NONE = 3'd0,
        CLS_ADD  = 3'd1,
        CLS_LW   = 3'd2,
        CLS_SW   = 3'd3,
        CLS_BEQ  = 3'd4,
        CLS_J    = 3'd5
    } op_class_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ILLEGAL    = 2'd1,
        ST_ADDR_RANGE = 2'd2,
        ST_HALTED     = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] next_pc;
        op_class_t   op_class;
        status_t     status;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
        logic        mem_written;
        logic [5:0]  mem_slot;
        logic [31:0] mem_value;
        logic        branch_taken;
    } result_t;

endpackage

>>> sv/mscs_ram.sv
module mscs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mscs_out_fifo.sv
module mscs_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mscs_pkg::result_t push_data,
    output logic              not_full,
    input  logic              out_ready,
    output logic              out_valid,
    output mscs_pkg::result_t out_data
);

    mscs_pkg::result_t q0_reg, q0_next;
    mscs_pkg::result_t q1_reg, q1_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = q0_reg;
    assign not_full  = (count_reg != 2'd2);

    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg;
        if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                q0_next = push_data;
            end
            else
            begin
                q0_next = q1_reg;
                q1_next = push_data;
            end
        end
        else if (pop)
        begin
            q0_next    = q1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                q0_next = push_data;
            end
            else
            begin
                q1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == 2'd2))
        else $error("result pushed into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == 2'd2) |=> (count_reg == 2'd1 && out_valid))
        else $error("queue lost its second word");

endmodule

>>> sv/mscs_core.sv
module mscs_core #(
    parameter int MEM_WORDS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mscs_pkg::mode_t   in_mode,
    input  logic [5:0]        in_index,
    input  logic [31:0]       in_value,
    input  logic              fifo_ok,
    output logic              push,
    output mscs_pkg::result_t res
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);
    localparam logic [31:0]   MEM_LIMIT = 32'(MEM_WORDS);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DECODE = 5'b00100,
        S_EXEC   = 5'b01000,
        S_LOAD   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [31:0]   pc_reg, pc_next;
    logic [31:0]   inst_reg, inst_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [31:0]   valid_reg, valid_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    logic          rf_we;
    logic [4:0]    rf_waddr, rf_raddr_a, rf_raddr_b;
    logic [31:0]   rf_wdata, rf_rdata_a, rf_rdata_b;

    logic [31:0]   idx_ext;
    logic          pc_ok;
    logic [5:0]    ex_opc;
    logic [4:0]    ex_rs, ex_rt, ex_rd;
    logic [31:0]   ex_imm, ex_a, ex_b, ex_pc4, ex_addr, ex_sum;
    logic [31:0]   ex_beq_target, ex_jump_target;
    logic          ex_addr_ok;

    mscs_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // two copies of the register file, one per read operand
    mscs_ram #(.WIDTH(32), .DEPTH(mscs_pkg::REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_a),
        .rdata (rf_rdata_a)
    );

    mscs_ram #(.WIDTH(32), .DEPTH(mscs_pkg::REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_b),
        .rdata (rf_rdata_b)
    );

    assign idx_ext = 32'(in_index);
    assign pc_ok   = (pc_reg < MEM_LIMIT);

    assign ex_opc = inst_reg[31:26];
    assign ex_rs  = inst_reg[25:21];
    assign ex_rt  = inst_reg[20:16];
    assign ex_rd  = inst_reg[15:11];
    assign ex_imm = {{16{inst_reg[15]}}, inst_reg[15:0]};
    // a register never written since reset reads as zero
    assign ex_a   = (ex_rs != 5'd0 && valid_reg[ex_rs]) ? rf_rdata_a : 32'd0;
    assign ex_b   = (ex_rt != 5'd0 && valid_reg[ex_rt]) ? rf_rdata_b : 32'd0;
    assign ex_pc4 = pc_reg + 32'd4;
    assign ex_sum = ex_a + ex_b;
    assign ex_addr    = ex_a + ex_imm;
    assign ex_addr_ok = (ex_addr < MEM_LIMIT);
    assign ex_beq_target  = ex_pc4 + {ex_imm[29:0], 2'b00};
    assign ex_jump_target = (ex_pc4 & mscs_pkg::JUMP_HI_MASK)
                          | {4'b0000, inst_reg[25:0], 2'b00};

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        inst_next  = inst_reg;
        clr_next   = clr_reg;
        valid_next = valid_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = 32'd0;
        mem_raddr  = pc_reg[AW-1:0];
        rf_we      = 1'b0;
        rf_waddr   = ex_rt;
        rf_wdata   = 32'd0;
        rf_raddr_a = mem_rdata[25:21];
        rf_raddr_b = mem_rdata[20:16];
        res         = '0;
        res.next_pc = pc_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = fifo_ok;
                if (in_valid && fifo_ok)
                begin
                    unique case (in_mode)
                        mscs_pkg::MODE_LOAD_MEM:
                        begin
                            push = 1'b1;
                            if (idx_ext < MEM_LIMIT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_ext[AW-1:0];
                                mem_wdata = in_value;
                            end
                        end
                        mscs_pkg::MODE_LOAD_REG:
                        begin
                            push = 1'b1;
                            if (!in_index[5] && in_index[4:0] != 5'd0)
                            begin
                                rf_we      = 1'b1;
                                rf_waddr   = in_index[4:0];
                                rf_wdata   = in_value;
                                valid_next[in_index[4:0]] = 1'b1;
                            end
                        end
                        mscs_pkg::MODE_STEP:
                        begin
                            // fetch address is pc, already on the read port
                            if (pc_ok)
                            begin
                                state_next = S_DECODE;
                            end
                            else
                            begin
                                push       = 1'b1;
                                res.status = mscs_pkg::ST_HALTED;
                            end
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            S_DECODE:
            begin
                inst_next  = mem_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                pc_next     = ex_pc4;
                res.next_pc = ex_pc4;
                push        = 1'b1;
                state_next  = S_IDLE;
                unique case (ex_opc)
                    mscs_pkg::OP_RTYPE:
                    begin
                        res.op_class = mscs_pkg::CLS_ADD;
                        if (ex_rd != 5'd0)
                        begin
                            rf_we          = 1'b1;
                            rf_waddr       = ex_rd;
                            rf_wdata       = ex_sum;
                            valid_next[ex_rd] = 1'b1;
                            res.reg_written = 1'b1;
                            res.dest_reg    = ex_rd;
                            res.dest_value  = ex_sum;
                        end
                    end
                    mscs_pkg::OP_LW:
                    begin
                        res.op_class = mscs_pkg::CLS_LW;
                        if (!ex_addr_ok)
                        begin
                            res.status = mscs_pkg::ST_ADDR_RANGE;
                        end
                        else
                        begin
                            // hold the result until the data word returns
                            push       = 1'b0;
                            mem_raddr  = ex_addr[AW-1:0];
                            state_next = S_LOAD;
                        end
                    end
                    mscs_pkg::OP_SW:
                    begin
                        res.op_class = mscs_pkg::CLS_SW;
                        if (!ex_addr_ok)
                        begin
                            res.status = mscs_pkg::ST_ADDR_RANGE;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = ex_addr[AW-1:0];
                            mem_wdata       = ex_b;
                            res.mem_written = 1'b1;
                            res.mem_slot    = ex_addr[5:0];
                            res.mem_value   = ex_b;
                        end
                    end
                    mscs_pkg::OP_BEQ:
                    begin
                        res.op_class = mscs_pkg::CLS_BEQ;
                        if (ex_a == ex_b)
                        begin
                            pc_next          = ex_beq_target;
                            res.next_pc      = ex_beq_target;
                            res.branch_taken = 1'b1;
                        end
                    end
                    mscs_pkg::OP_J:
                    begin
                        res.op_class     = mscs_pkg::CLS_J;
                        pc_next          = ex_jump_target;
                        res.next_pc      = ex_jump_target;
                        res.branch_taken = 1'b1;
                    end
                    default:
                    begin
                        res.status = mscs_pkg::ST_ILLEGAL;
                    end
                endcase
            end
            S_LOAD:
            begin
                // pc already advanced in the execute cycle
                push         = 1'b1;
                res.op_class = mscs_pkg::CLS_LW;
                state_next   = S_IDLE;
                if (ex_rt != 5'd0)
                begin
                    rf_we          = 1'b1;
                    rf_waddr       = ex_rt;
                    rf_wdata       = mem_rdata;
                    valid_next[ex_rt] = 1'b1;
                    res.reg_written = 1'b1;
                    res.dest_reg    = ex_rt;
                    res.dest_value  = mem_rdata;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= 32'd0;
            clr_reg   <= '0;
            valid_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            clr_reg   <= clr_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inst_reg <= inst_next;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> fifo_ok)
        else $error("result produced with no queue room");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("word accepted during memory clear");

    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (rf_waddr != 5'd0))
        else $error("write to register zero");

    a_decode_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE) |=> (state_reg == S_EXEC))
        else $error("decode did not advance to execute");

    a_exec_store_only: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_EXEC) |-> (ex_opc == mscs_pkg::OP_SW))
        else $error("memory write in execute without a store");

endmodule

>>> sv/mips_single_cycle_subset_top.sv
// Channel | Direction | Handshake           | Payload
// s_*     | in        | s_tvalid / s_tready | s_tuser: mode; s_tdata: load_index, load_value
// m_*     | out       | m_tvalid / m_tready | m_tuser: op_class, status; m_tdata: result word
//
// A load word is written in the idle state. A step runs fetch, register read, execute
// in turn, plus a data read for lw, set by the serial reads of the shared word memory
// and the register file. After reset a clearing pass writes zeros over every word of
// the word memory, with s_tready low.
// Results go through a two-word output queue: a new word is accepted while one
// result waits. s_tready is low while a step is in progress, and in the idle state
// it drops only while the queue holds two.
module mips_single_cycle_subset_top #(
    parameter int MEM_WORDS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // load_index[5:0], load_value[37:6], zero pad
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // next_pc[31:0], reg_written[32], dest_reg[37:33],
                                    // dest_value[69:38], mem_written[70],
                                    // mem_slot[76:71], mem_value[108:77],
                                    // branch_taken[109], zero pad
    output logic [4:0]   m_tuser    // op_class[2:0], status[4:3]
);

    logic              push;
    logic              fifo_ok;
    mscs_pkg::result_t res;
    mscs_pkg::result_t out_res;

    mscs_core #(.MEM_WORDS(MEM_WORDS)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (mscs_pkg::mode_t'(s_tuser)),
        .in_index (s_tdata[5:0]),
        .in_value (s_tdata[37:6]),
        .fifo_ok  (fifo_ok),
        .push     (push),
        .res      (res)
    );

    mscs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .not_full  (fifo_ok),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res)
    );

    assign m_tdata = {2'b00,
                      out_res.branch_taken,
                      out_res.mem_value,
                      out_res.mem_slot,
                      out_res.mem_written,
                      out_res.dest_value,
                      out_res.dest_reg,
                      out_res.reg_written,
                      out_res.next_pc};
    assign m_tuser = {out_res.status, out_res.op_class};

endmodule
